// ===== rtl/e2q_pkg.sv =====
// e2q_pkg: constants, types and arctangent table for euler_to_quaternion
// used by the channel interfaces and the top level
package e2q_pkg;

  localparam int unsigned FieldBits   = 16;
  localparam int unsigned CordicSteps = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [FieldBits-1:0] roll_angle;
    logic signed [FieldBits-1:0] pitch_angle;
    logic signed [FieldBits-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] w_component;
    logic signed [FieldBits-1:0] x_component;
    logic signed [FieldBits-1:0] y_component;
    logic signed [FieldBits-1:0] z_component;
  } quat_t;

  // arctangent of 2^-i in phase units, 2^32 per full turn
  function automatic logic signed [33:0] atan_phase(input int unsigned i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/e2q_if.sv =====
// e2q_angles_if, e2q_quat_if: valid/ready channels for angles and quaternions
// depend on e2q_pkg
interface e2q_angles_if;
  logic valid;
  logic ready;
  e2q_pkg::angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface e2q_quat_if;
  logic valid;
  logic ready;
  e2q_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/euler_to_quaternion.sv =====
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion, fully pipelined
// depends on e2q_pkg and the channels in e2q_if.sv
//
// Takes one transfer of roll, pitch and yaw per cycle and gives w, x, y, z in
// signed Q1.FRACTION_BITS. Stages: one input register, 30 CORDIC
// stages (one rotation step each, three rotators side by side), two stages
// for the first products, two for the second products, one for the sums and
// rounding. Throughput is one item per cycle; a stall freezes all stages.
module euler_to_quaternion #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_angles_if.sink  in_i,
  e2q_quat_if.source  out_o
);
  localparam int unsigned Steps  = e2q_pkg::CordicSteps;
  localparam int unsigned Stages = Steps + 6;
  localparam int unsigned Fb     = e2q_pkg::FieldBits;

  typedef logic signed [33:0] w34_t;

  logic [Stages-1:0] vld_q;
  logic              adv;
  assign adv = out_o.ready || !vld_q[Stages-1];
  assign in_i.ready = adv;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_i.valid};
    end
  end

  // angle to phase
  function automatic w34_t to_phase(input logic [Fb-1:0] raw);
    logic signed [ANGLE_BITS-1:0] a;
    logic signed [63:0] e;
    a = ANGLE_BITS'(raw);
    e = 64'(a);
    if (ANGLE_BITS <= 31) e = e <<< (31 - ANGLE_BITS);
    else e = e >>> (ANGLE_BITS - 31);
    return 34'(e);
  endfunction

  w34_t cx_q [3][Steps+1];
  w34_t cy_q [3][Steps+1];
  w34_t cz_q [3][Steps+1];

  // input register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0][0] <= e2q_pkg::CordicGain; cy_q[0][0] <= '0;
      cx_q[1][0] <= e2q_pkg::CordicGain; cy_q[1][0] <= '0;
      cx_q[2][0] <= e2q_pkg::CordicGain; cy_q[2][0] <= '0;
      cz_q[0][0] <= to_phase(in_i.data.roll_angle);
      cz_q[1][0] <= to_phase(in_i.data.pitch_angle);
      cz_q[2][0] <= to_phase(in_i.data.yaw_angle);
    end
  end

  // cordic rotation stages
  for (genvar a = 0; a < 3; a++) begin : g_ax
    for (genvar i = 0; i < Steps; i++) begin : g_st
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (!cz_q[a][i][33]) begin
            cx_q[a][i+1] <= cx_q[a][i] - (cy_q[a][i] >>> i);
            cy_q[a][i+1] <= cy_q[a][i] + (cx_q[a][i] >>> i);
            cz_q[a][i+1] <= cz_q[a][i] - e2q_pkg::atan_phase(i);
          end else begin
            cx_q[a][i+1] <= cx_q[a][i] + (cy_q[a][i] >>> i);
            cy_q[a][i+1] <= cy_q[a][i] - (cx_q[a][i] >>> i);
            cz_q[a][i+1] <= cz_q[a][i] + e2q_pkg::atan_phase(i);
          end
        end
      end
    end
  end

  // s/c per axis: index 0 roll, 1 pitch, 2 yaw
  w34_t c [3], s [3];
  for (genvar a = 0; a < 3; a++) begin : g_sc
    assign c[a] = cx_q[a][Steps];
    assign s[a] = cy_q[a][Steps];
  end

  // eight terms: bit2 roll sin, bit1 pitch sin, bit0 yaw sin
  logic signed [67:0] p1_q [8];
  w34_t               r1_q [8];
  w34_t               t3_q [8], t3b_q [8];
  logic signed [67:0] p2_q [8];
  for (genvar k = 0; k < 8; k++) begin : g_tm
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p1_q[k]  <= 68'(((k & 4) != 0 ? s[0] : c[0])) * 68'(((k & 2) != 0 ? s[1] : c[1]));
        t3_q[k]  <= (k & 1) != 0 ? s[2] : c[2];
        r1_q[k]  <= 34'((p1_q[k] + 68'sd536870912) >>> 30);
        t3b_q[k] <= t3_q[k];
        p2_q[k]  <= 68'(r1_q[k]) * 68'(t3b_q[k]);
      end
    end
  end

  logic signed [67:0] p3_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) p3_q <= p2_q;
  end

  function automatic logic [Fb-1:0] finish(input logic signed [67:0] v);
    logic signed [67:0] r;
    logic signed [67:0] one;
    one = 68'sd1 <<< FRACTION_BITS;
    r = (v + (68'sd1 <<< (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[Fb-1:0];
  endfunction

  // sums, rounding and saturation
  e2q_pkg::quat_t q_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_q.w_component <= finish(p3_q[0] + p3_q[7]);
      q_q.x_component <= finish(p3_q[4] - p3_q[3]);
      q_q.y_component <= finish(p3_q[2] + p3_q[5]);
      q_q.z_component <= finish(p3_q[1] - p3_q[6]);
    end
  end

  assign out_o.valid = vld_q[Stages-1];
  assign out_o.data  = q_q;
endmodule
